// File: rtl/fap_pkg.sv
// Package for the fixed-point ALU: command codes, widths and the carried result record.
// No dependencies.
package fap_pkg;

  localparam int unsigned FractionBitsDef = 14;
  localparam int unsigned DataW = 32;
  localparam int unsigned CmdW = 4;

  typedef enum logic [CmdW-1:0] {
    CmdToFix = 4'd0,
    CmdTrunc = 4'd1,
    CmdRound = 4'd2,
    CmdAddFF = 4'd3,
    CmdSubFF = 4'd4,
    CmdAddFI = 4'd5,
    CmdSubFI = 4'd6,
    CmdMulFF = 4'd7,
    CmdMulFI = 4'd8,
    CmdDivFF = 4'd9,
    CmdDivFI = 4'd10
  } cmd_e;

  // result of the non-divide path, plus divide control, carried alongside the divider
  typedef struct packed {
    logic [DataW-1:0] res;
    logic             ovf;
    logic             dz;
    logic             is_div;
    logic             neg;
  } carry_t;

endpackage

// File: rtl/fap_if.sv
// Valid/ready channel interfaces for request and result of the fixed-point ALU.
// Depends on fap_pkg.
interface fap_in_if;
  logic                                valid;
  logic                                ready;
  logic [fap_pkg::CmdW-1:0]            cmd;
  logic signed [fap_pkg::DataW-1:0]    operand_a;
  logic signed [fap_pkg::DataW-1:0]    operand_b;
  modport source (output valid, cmd, operand_a, operand_b, input ready);
  modport sink   (input valid, cmd, operand_a, operand_b, output ready);
endinterface

interface fap_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [fap_pkg::DataW-1:0]    result;
  logic                                overflow;
  logic                                divide_by_zero;
  modport source (output valid, result, overflow, divide_by_zero, input ready);
  modport sink   (input valid, result, overflow, divide_by_zero, output ready);
endinterface

// File: rtl/fap_front.sv
// Front end: operand register with 32x32 multiply, then operation decode,
// non-divide results with overflow, and divider operand preparation. Depends on fap_pkg.
module fap_front #(
  parameter int unsigned FRACTION_BITS = fap_pkg::FractionBitsDef,
  localparam int unsigned QW = fap_pkg::DataW + FRACTION_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [fap_pkg::CmdW-1:0]   cmd_i,
  input  logic [fap_pkg::DataW-1:0]  a_i,
  input  logic [fap_pkg::DataW-1:0]  b_i,
  output logic                       valid_o,
  output fap_pkg::carry_t            carry_o,
  output logic [QW-1:0]              dividend_o,
  output logic [fap_pkg::DataW-1:0]  divisor_o
);
  localparam int unsigned DW = fap_pkg::DataW;
  localparam logic signed [63:0] One  = 64'sd1 <<< FRACTION_BITS;
  localparam logic signed [63:0] Half = 64'sd1 <<< (FRACTION_BITS - 1);

  logic                    v1_q, v2_q;
  logic [fap_pkg::CmdW-1:0] cmd_q;
  logic [DW-1:0]           a_q, b_q;
  logic signed [63:0]      prod_q;

  logic signed [63:0]      sa, sb, x, exact;
  logic [DW-1:0]           mag_a, mag_b;
  fap_pkg::carry_t         carry_d, carry_q;
  logic [QW-1:0]           dvd_d, dvd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd_q   <= cmd_i;
      a_q     <= a_i;
      b_q     <= b_i;
      prod_q  <= $signed(a_i) * $signed(b_i);
      carry_q <= carry_d;
      dvd_q   <= dvd_d;
      divisor_o <= mag_b;
    end
  end

  always_comb begin
    sa    = {{32{a_q[DW-1]}}, a_q};
    sb    = {{32{b_q[DW-1]}}, b_q};
    mag_a = a_q[DW-1] ? (~a_q + 1'b1) : a_q;
    mag_b = b_q[DW-1] ? (~b_q + 1'b1) : b_q;
    x     = '0;
    exact = '0;
    dvd_d = '0;
    carry_d = '0;
    carry_d.neg = a_q[DW-1] ^ b_q[DW-1];
    unique case (fap_pkg::cmd_e'(cmd_q))
      fap_pkg::CmdToFix: exact = sb <<< FRACTION_BITS;
      fap_pkg::CmdTrunc: begin
        x = a_q[DW-1] ? (sa + One - 64'sd1) : sa;
        exact = x >>> FRACTION_BITS;
      end
      fap_pkg::CmdRound: begin
        x = a_q[DW-1] ? (sa - Half + One - 64'sd1) : (sa + Half);
        exact = x >>> FRACTION_BITS;
      end
      fap_pkg::CmdAddFF: exact = sa + sb;
      fap_pkg::CmdSubFF: exact = sa - sb;
      fap_pkg::CmdAddFI: exact = sa + (sb <<< FRACTION_BITS);
      fap_pkg::CmdSubFI: exact = sa - (sb <<< FRACTION_BITS);
      fap_pkg::CmdMulFF: exact = prod_q >>> FRACTION_BITS;
      fap_pkg::CmdMulFI: exact = prod_q;
      fap_pkg::CmdDivFF: begin
        carry_d.is_div = 1'b1;
        dvd_d = {mag_a, {FRACTION_BITS{1'b0}}};
      end
      fap_pkg::CmdDivFI: begin
        carry_d.is_div = 1'b1;
        dvd_d = {{FRACTION_BITS{1'b0}}, mag_a};
      end
      default: exact = '0;
    endcase
    carry_d.dz  = carry_d.is_div && (b_q == '0);
    carry_d.res = exact[DW-1:0];
    carry_d.ovf = !((&exact[63:DW-1]) || !(|exact[63:DW-1]));
  end

  assign valid_o    = v2_q;
  assign carry_o    = carry_q;
  assign dividend_o = dvd_q;
endmodule

// File: rtl/fap_div.sv
// Pipelined restoring divider, one quotient bit per stage, carrying the
// non-divide result alongside. Depends on fap_pkg.
module fap_div #(
  parameter int unsigned FRACTION_BITS = fap_pkg::FractionBitsDef,
  localparam int unsigned QW = fap_pkg::DataW + FRACTION_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  fap_pkg::carry_t            carry_i,
  input  logic [QW-1:0]              dividend_i,
  input  logic [fap_pkg::DataW-1:0]  divisor_i,
  output logic                       valid_o,
  output fap_pkg::carry_t            carry_o,
  output logic [QW-1:0]              quotient_o
);
  localparam int unsigned DW = fap_pkg::DataW;

  logic                  vld [QW+1];
  fap_pkg::carry_t       cry [QW+1];
  logic [QW-1:0]         nq  [QW+1];
  logic [DW-1:0]         rem [QW+1];
  logic [DW-1:0]         dv  [QW+1];

  assign vld[0] = valid_i;
  assign cry[0] = carry_i;
  assign nq[0]  = dividend_i;
  assign rem[0] = '0;
  assign dv[0]  = divisor_i;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW:0] rs, diff;
    logic        ge;
    assign rs   = {rem[s], nq[s][QW-1]};
    assign ge   = rs >= {1'b0, dv[s]};
    assign diff = rs - {1'b0, dv[s]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[s+1] <= 1'b0;
      end else if (en_i) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cry[s+1] <= cry[s];
        dv[s+1]  <= dv[s];
        nq[s+1]  <= {nq[s][QW-2:0], ge};
        rem[s+1] <= ge ? diff[DW-1:0] : rs[DW-1:0];
      end
    end
  end

  assign valid_o    = vld[QW];
  assign carry_o    = cry[QW];
  assign quotient_o = nq[QW];
endmodule

// File: rtl/fixed_point_alu.sv
// Signed 32-bit fixed-point ALU, top level: front end, divider pipeline, output register.
// Depends on fap_pkg, fap_if, fap_front and fap_div.
//
// Accepts one request per cycle while no result waits at the output. Every request
// passes through the front end, the divider pipeline and the output register; the
// divider pipeline resolves one quotient bit per stage, and all commands pass through
// it to keep results in order. The whole pipeline stalls together while a result
// waits at the output.
module fixed_point_alu #(
  parameter int unsigned FRACTION_BITS = fap_pkg::FractionBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fap_in_if.sink    in_i,
  fap_out_if.source out_o
);
  localparam int unsigned DW = fap_pkg::DataW;
  localparam int unsigned QW = DW + FRACTION_BITS;

  logic            en;
  logic            fv, dvv;
  fap_pkg::carry_t fc, dc;
  logic [QW-1:0]   fdvd, quo;
  logic [DW-1:0]   fdvs;

  logic            valid_q;
  logic [DW-1:0]   res_d, res_q;
  logic            ovf_d, ovf_q, dz_q;
  logic            hi;

  assign en        = !valid_q || out_o.ready;
  assign in_i.ready = en;

  fap_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(in_i.valid && en), .cmd_i(in_i.cmd),
    .a_i(in_i.operand_a), .b_i(in_i.operand_b),
    .valid_o(fv), .carry_o(fc), .dividend_o(fdvd), .divisor_o(fdvs)
  );

  fap_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(fv), .carry_i(fc), .dividend_i(fdvd), .divisor_i(fdvs),
    .valid_o(dvv), .carry_o(dc), .quotient_o(quo)
  );

  always_comb begin
    hi = |quo[QW-1:DW];
    res_d = dc.res;
    ovf_d = dc.ovf;
    if (dc.is_div) begin
      if (dc.dz) begin
        res_d = '0;
        ovf_d = 1'b0;
      end else if (dc.neg) begin
        res_d = ~quo[DW-1:0] + 1'b1;
        ovf_d = hi || (quo[DW-1:0] > {1'b1, {(DW-1){1'b0}}});
      end else begin
        res_d = quo[DW-1:0];
        ovf_d = hi || quo[DW-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= dvv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      ovf_q <= ovf_d;
      dz_q  <= dc.dz;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.result         = res_q;
  assign out_o.overflow       = ovf_q;
  assign out_o.divide_by_zero = dz_q;
endmodule

// File: verif/fixed_point_alu_checker.sv
// Checker for the fixed-point ALU: watches request and result channels, predicts each result
// and compares the actual result and both flags with it. Depends on fap_pkg and fap_if.
`timescale 1ns / 100ps
module fixed_point_alu_checker #(
  parameter int unsigned FRACTION_BITS = fap_pkg::FractionBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fap_in_if         in_i,
  fap_out_if        out_o,
  output int        fail_count_o,
  output int        pending_o
);

  typedef struct packed {
    logic [fap_pkg::DataW-1:0] result;
    logic                      overflow;
    logic                      divide_by_zero;
  } alu_result_t;

  alu_result_t expected_q[$];

  function automatic logic signed [127:0] div_trunc(logic signed [127:0] n,
                                                    logic signed [127:0] d);
    logic [127:0] un, ud, q;
    logic         neg;
    neg = n[127] ^ d[127];
    un = n[127] ? -n : n;
    ud = d[127] ? -d : d;
    q = un / ud;
    return neg ? -$signed(q) : $signed(q);
  endfunction

  function automatic alu_result_t compute_alu(logic [fap_pkg::CmdW-1:0] cmd,
                                              logic signed [fap_pkg::DataW-1:0] a32,
                                              logic signed [fap_pkg::DataW-1:0] b32);
    logic signed [127:0] a, b, one, half, exact;
    alu_result_t r;
    a = a32;
    b = b32;
    one = 128'sd1 <<< FRACTION_BITS;
    half = 128'sd1 <<< (FRACTION_BITS - 1);
    exact = 0;
    r.divide_by_zero = 1'b0;
    case (cmd)
      fap_pkg::CmdToFix: exact = b * one;
      fap_pkg::CmdTrunc: exact = div_trunc(a, one);
      fap_pkg::CmdRound:
        exact = (a >= 0) ? div_trunc(a + half, one) : div_trunc(a - half, one);
      fap_pkg::CmdAddFF: exact = a + b;
      fap_pkg::CmdSubFF: exact = a - b;
      fap_pkg::CmdAddFI: exact = a + b * one;
      fap_pkg::CmdSubFI: exact = a - b * one;
      fap_pkg::CmdMulFF: exact = (a * b) >>> FRACTION_BITS;
      fap_pkg::CmdMulFI: exact = a * b;
      fap_pkg::CmdDivFF:
        if (b == 0) r.divide_by_zero = 1'b1; else exact = div_trunc(a * one, b);
      fap_pkg::CmdDivFI:
        if (b == 0) r.divide_by_zero = 1'b1; else exact = div_trunc(a, b);
      default: exact = 0;
    endcase
    r.result = exact[fap_pkg::DataW-1:0];
    r.overflow = (exact < -(128'sd1 <<< 31)) || (exact > ((128'sd1 <<< 31) - 1));
    return r;
  endfunction

  assign pending_o = expected_q.size();

  initial fail_count_o = 0;

  always @(posedge clk_i) begin
    alu_result_t got, want;
    if (rst_ni) begin
      if (in_i.valid && in_i.ready)
        expected_q.push_back(compute_alu(in_i.cmd, in_i.operand_a, in_i.operand_b));
      if (out_o.valid && out_o.ready) begin
        got = {out_o.result, out_o.overflow, out_o.divide_by_zero};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, actual %h/%b/%b", $time, got.result,
                   got.overflow, got.divide_by_zero);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected %h/%b/%b actual %h/%b/%b", $time,
                     want.result, want.overflow, want.divide_by_zero,
                     got.result, got.overflow, got.divide_by_zero);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

// File: verif/fixed_point_alu_test.sv
// Testbench top for the fixed-point ALU: directed and random requests with random idling.
// Depends on fap_pkg, fap_if, fixed_point_alu and fixed_point_alu_checker.
`timescale 1ns / 100ps
module fixed_point_alu_test;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending;
  bit   requests_done = 1'b0;

  fap_in_if  req_if ();
  fap_out_if res_if ();

  fixed_point_alu dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(req_if.sink), .out_o(res_if.source));

  fixed_point_alu_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(req_if), .out_o(res_if),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    req_if.valid = 1'b0;
    req_if.cmd = '0;
    req_if.operand_a = '0;
    req_if.operand_b = '0;
    res_if.ready = 1'b0;
  end

  // valid stays high into a back-to-back request; it drops only before idling
  task automatic send_request(logic [fap_pkg::CmdW-1:0] cmd, logic [31:0] a, logic [31:0] b);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.cmd <= cmd;
    req_if.operand_a <= a;
    req_if.operand_b <= b;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 64)) - 32);
      3: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      4: return $urandom_range(0, 1) ? 32'h0000_4000 : 32'hffff_c000;
      default: return $urandom();
    endcase
  endfunction

  // result side stalls at random, with stall-free stretches
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  initial begin
    logic [31:0] edges[6];
    edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1, 32'hffff_ffff, 32'h0000_2000};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int c = 0; c <= fap_pkg::CmdDivFI; c++)
      send_request(c[fap_pkg::CmdW-1:0], edges[c % 6], edges[(c + 1) % 6]);
    send_request(fap_pkg::CmdDivFF, 32'h0001_0000, 32'h0);
    send_request(fap_pkg::CmdDivFI, 32'h8000_0000, 32'h0);
    send_request(fap_pkg::CmdDivFI, 32'h8000_0000, 32'hffff_ffff);
    send_request(fap_pkg::CmdRound, 32'hffff_e000, 32'h0);
    send_request(fap_pkg::CmdRound, 32'h0000_2000, 32'h0);
    send_request(fap_pkg::CmdTrunc, 32'hffff_ffff, 32'h0);
    send_request(fap_pkg::CmdMulFF, 32'hffff_ffff, 32'h0000_0001);
    send_request(fap_pkg::CmdMulFI, 32'h8000_0000, 32'h8000_0000);
    send_request(4'd11, 32'h1234_5678, 32'h1);
    send_request(4'd15, 32'hffff_ffff, 32'hffff_ffff);
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    for (int i = 0; i < 1030; i++) begin
      logic [fap_pkg::CmdW-1:0] cmd;
      cmd = ($urandom_range(0, 19) == 0) ? fap_pkg::CmdW'($urandom_range(11, 15))
                                         : fap_pkg::CmdW'($urandom_range(0, 10));
      send_request(cmd, pick_operand(), pick_operand());
    end
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    requests_done = 1'b1;
  end

  initial begin
    wait (requests_done);
    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (fail_count == 0)
      $display("fixed_point_alu test passed");
    else
      $display("fixed_point_alu test failed");
    $finish;
  end

  initial begin
    #200000;
    $display("fixed_point_alu test failed");
    $finish;
  end
endmodule
